/* rtl/ptad_pkg.sv */
// ----------------------------------------------------------------------------
// ptad_pkg
// Types, constants and elaboration-time helpers for point_to_arc_distance.
// ----------------------------------------------------------------------------
package ptad_pkg;

  localparam int FRAC_BITS    = 28;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
  localparam int GUARD        = 20;

  // fixed-point widths
  localparam int ANG_W  = 34;        // angles, Q28 plus headroom
  localparam int CW     = 64;        // cordic datapath
  localparam int LEN_W  = 35;        // signed coordinate differences
  localparam int ABS_W  = 34;        // their magnitudes
  localparam int RAD_W  = 70;        // radicand
  localparam int ROOT_W = 35;        // integer square root
  localparam int REM_W  = ROOT_W + 3;

  // pipeline latencies
  localparam int LAT_SQRT  = 3 + ROOT_W;
  localparam int LAT_VEC   = 2 + CORDIC_STEPS;
  localparam int THETA_DLY = LAT_SQRT - LAT_VEC;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [CW-1:0]    cw_t;

  localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C234;
  localparam logic [29:0] KINV_Q30 = 30'd652032874;

  localparam ang_t PI_Q =
    ang_t'((PI_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
  localparam ang_t HALF_PI_Q =
    ang_t'((PI_Q62 + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS));

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARC_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ANGLE   = 3'd4;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_t;

  typedef struct packed {
    logic [31:0] arc_distance;
    logic        angle_error;
  } out_t;

  // arc endpoints in absolute coordinates
  typedef struct packed {
    logic signed [ABS_W-1:0] e0x;
    logic signed [ABS_W-1:0] e0y;
    logic signed [ABS_W-1:0] e1x;
    logic signed [ABS_W-1:0] e1y;
  } ep_t;

  // shift-subtract divide, used on constants only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) from a truncated series at Q62, rounded to Q28
  function automatic ang_t atan_q(int i);
    logic [63:0] acc;
    logic [63:0] term;
    int k;
    acc = '0;
    if (i == 0) begin
      acc = PI_Q62 >> 2;
    end else begin
      k = 0;
      while (i * (2 * k + 1) <= 62) begin
        term = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
        if (k % 2 == 1) acc = acc - term;
        else            acc = acc + term;
        k = k + 1;
      end
    end
    return ang_t'((acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
  endfunction

  // index of the highest set bit
  function automatic logic [5:0] msb_idx(logic [ABS_W-1:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int b = 0; b < ABS_W; b++) begin
      if (v[b]) idx = 6'(b);
    end
    return idx;
  endfunction

endpackage

/* rtl/ptad_vec_cordic.sv */
// ----------------------------------------------------------------------------
// ptad_vec_cordic
// Pipelined vectoring cordic: polar angle of (dx, dy), one stage per step.
// ----------------------------------------------------------------------------
module ptad_vec_cordic (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [32:0]   dx,
  input  logic signed [32:0]   dy,
  output ptad_pkg::ang_t       theta
);

  localparam int N = ptad_pkg::CORDIC_STEPS;

  logic signed [33:0]           x1_nxt, y1_nxt;
  ptad_pkg::ang_t               z1_nxt;
  logic [ptad_pkg::ABS_W-1:0]   ax, ay;
  logic [5:0]                   k1_nxt;
  logic                         zero1_nxt;

  logic signed [33:0]           x1_r, y1_r;
  ptad_pkg::ang_t               z1_r;
  logic [5:0]                   k1_r;
  logic                         zero1_r;

  ptad_pkg::cw_t                x_r [N+1];
  ptad_pkg::cw_t                y_r [N+1];
  ptad_pkg::ang_t               z_r [N+1];
  logic                         zero_r [N+1];

  // move to the right half plane and find the normalizing shift
  always_comb begin
    zero1_nxt = (dx == '0) && (dy == '0);
    if (dx < 0) begin
      x1_nxt = -{dx[32], dx};
      y1_nxt = -{dy[32], dy};
      z1_nxt = (dy >= 0) ? ptad_pkg::PI_Q : -ptad_pkg::PI_Q;
    end else begin
      x1_nxt = {dx[32], dx};
      y1_nxt = {dy[32], dy};
      z1_nxt = '0;
    end
    ax = x1_nxt[33] ? ptad_pkg::ABS_W'(-x1_nxt) : ptad_pkg::ABS_W'(x1_nxt);
    ay = y1_nxt[33] ? ptad_pkg::ABS_W'(-y1_nxt) : ptad_pkg::ABS_W'(y1_nxt);
    k1_nxt = 6'd57 - ptad_pkg::msb_idx(ax | ay);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x1_nxt;
      y1_r    <= y1_nxt;
      z1_r    <= z1_nxt;
      k1_r    <= k1_nxt;
      zero1_r <= zero1_nxt;
      x_r[0]    <= ptad_pkg::cw_t'(x1_r) <<< k1_r;
      y_r[0]    <= ptad_pkg::cw_t'(y1_r) <<< k1_r;
      z_r[0]    <= z1_r;
      zero_r[0] <= zero1_r;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    localparam ptad_pkg::ang_t ATAN_G = ptad_pkg::atan_q(g);
    ptad_pkg::cw_t xs, ys;
    assign xs = x_r[g] >>> g;
    assign ys = y_r[g] >>> g;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[g] >= 0) begin
          x_r[g+1] <= x_r[g] + ys;
          y_r[g+1] <= y_r[g] - xs;
          z_r[g+1] <= z_r[g] + ATAN_G;
        end else begin
          x_r[g+1] <= x_r[g] - ys;
          y_r[g+1] <= y_r[g] + xs;
          z_r[g+1] <= z_r[g] - ATAN_G;
        end
        zero_r[g+1] <= zero_r[g];
      end
    end
  end

  assign theta = zero_r[N] ? '0 : z_r[N];

endmodule

/* rtl/ptad_isqrt.sv */
// ----------------------------------------------------------------------------
// ptad_isqrt
// Pipelined floor(sqrt(a^2 + b^2)), one root bit per stage.
// ----------------------------------------------------------------------------
module ptad_isqrt (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ptad_pkg::LEN_W-1:0]   a,
  input  logic signed [ptad_pkg::LEN_W-1:0]   b,
  output logic [ptad_pkg::ROOT_W-1:0]         root
);

  localparam int AW = ptad_pkg::ABS_W;
  localparam int RW = ptad_pkg::ROOT_W;
  localparam int DW = ptad_pkg::RAD_W;
  localparam int MW = ptad_pkg::REM_W;

  logic [ptad_pkg::LEN_W-1:0] a_abs, b_abs;
  logic [AW-1:0]              a_r, b_r;
  logic [2*AW-1:0]            sa_r, sb_r;

  logic [DW-1:0] rad_r [RW+1];
  logic [MW-1:0] rem_r [RW+1];
  logic [RW-1:0] r_r   [RW+1];

  assign a_abs = a[ptad_pkg::LEN_W-1] ? ptad_pkg::LEN_W'(-a) : ptad_pkg::LEN_W'(a);
  assign b_abs = b[ptad_pkg::LEN_W-1] ? ptad_pkg::LEN_W'(-b) : ptad_pkg::LEN_W'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_abs[AW-1:0];
      b_r      <= b_abs[AW-1:0];
      sa_r     <= a_r * a_r;
      sb_r     <= b_r * b_r;
      rad_r[0] <= DW'(sa_r) + DW'(sb_r);
      rem_r[0] <= '0;
      r_r[0]   <= '0;
    end
  end

  for (genvar g = 0; g < RW; g++) begin : g_bit
    logic [MW-1:0] rem_t, trial;
    assign rem_t = {rem_r[g][MW-3:0], rad_r[g][DW-1 -: 2]};
    assign trial = MW'({r_r[g], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[g+1] <= {rad_r[g][DW-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem_r[g+1] <= rem_t - trial;
          r_r[g+1]   <= {r_r[g][RW-2:0], 1'b1};
        end else begin
          rem_r[g+1] <= rem_t;
          r_r[g+1]   <= {r_r[g][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = r_r[RW];

endmodule

/* rtl/ptad_rot_cordic.sv */
// ----------------------------------------------------------------------------
// ptad_rot_cordic
// Iterative rotation cordic that turns the configured angles into the two
// arc endpoints; rerun after every configuration transfer.
// ----------------------------------------------------------------------------
module ptad_rot_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [31:0]   center_x,
  input  logic signed [31:0]   center_y,
  input  logic [30:0]          arc_radius,
  input  logic signed [31:0]   start_angle,
  input  logic signed [31:0]   end_angle,
  output logic                 busy,
  output ptad_pkg::ep_t        ep
);

  localparam int N  = ptad_pkg::CORDIC_STEPS;
  localparam int IW = ptad_pkg::STEP_IDX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  ptad_pkg::ang_t atan_w [N];

  logic [1:0]     state_r, state_nxt;
  logic           sel_r, sel_nxt;
  logic [IW-1:0]  cnt_r, cnt_nxt;
  ptad_pkg::cw_t  x_r, x_nxt, y_r, y_nxt;
  ptad_pkg::ang_t z_r, z_nxt;
  logic           neg_r, neg_nxt;
  ptad_pkg::ep_t  ep_r, ep_nxt;

  logic [60:0]    prod;
  ptad_pkg::ang_t ang;
  ptad_pkg::cw_t  xs, ys, xr, yr;
  logic signed [32:0] c_res, s_res;
  logic signed [ptad_pkg::ABS_W-1:0] px, py;

  for (genvar g = 0; g < N; g++) begin : g_tab
    assign atan_w[g] = ptad_pkg::atan_q(g);
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    neg_nxt   = neg_r;
    ep_nxt    = ep_r;

    prod = arc_radius * ptad_pkg::KINV_Q30;
    ang  = sel_r ? ptad_pkg::ang_t'(end_angle) : ptad_pkg::ang_t'(start_angle);
    xs   = x_r >>> cnt_r;
    ys   = y_r >>> cnt_r;
    // drop the guard bits, round half up
    xr   = (x_r + (ptad_pkg::cw_t'(1) <<< (ptad_pkg::GUARD - 1))) >>> ptad_pkg::GUARD;
    yr   = (y_r + (ptad_pkg::cw_t'(1) <<< (ptad_pkg::GUARD - 1))) >>> ptad_pkg::GUARD;
    c_res = neg_r ? -33'(xr) : 33'(xr);
    s_res = neg_r ? -33'(yr) : 33'(yr);
    px    = ptad_pkg::ABS_W'(center_x) + ptad_pkg::ABS_W'(c_res);
    py    = ptad_pkg::ABS_W'(center_y) + ptad_pkg::ABS_W'(s_res);

    unique case (state_r)
      ST_IDLE: begin
      end
      ST_MUL: begin
        x_nxt   = ptad_pkg::cw_t'(prod >> (30 - ptad_pkg::GUARD));
        y_nxt   = '0;
        cnt_nxt = '0;
        // fold into the right half plane, negate the result later
        if (ang > ptad_pkg::HALF_PI_Q) begin
          z_nxt   = ang - ptad_pkg::PI_Q;
          neg_nxt = 1'b1;
        end else if (ang < -ptad_pkg::HALF_PI_Q) begin
          z_nxt   = ang + ptad_pkg::PI_Q;
          neg_nxt = 1'b1;
        end else begin
          z_nxt   = ang;
          neg_nxt = 1'b0;
        end
        state_nxt = ST_ITER;
      end
      ST_ITER: begin
        if (z_r >= 0) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atan_w[cnt_r];
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atan_w[cnt_r];
        end
        if (cnt_r == IW'(N - 1)) state_nxt = ST_DONE;
        else                     cnt_nxt   = cnt_r + 1'b1;
      end
      ST_DONE: begin
        if (sel_r) begin
          ep_nxt.e1x = px;
          ep_nxt.e1y = py;
          state_nxt  = ST_IDLE;
        end else begin
          ep_nxt.e0x = px;
          ep_nxt.e0y = py;
          sel_nxt    = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (start) begin
      state_nxt = ST_MUL;
      sel_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= 1'b0;
      ep_r    <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      ep_r    <= ep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign ep   = ep_r;

endmodule

/* rtl/point_to_arc_distance.sv */
// ----------------------------------------------------------------------------
// point_to_arc_distance
// Distance from a 2-D point to a configured circular arc, Q3.28 fixed point.
// ----------------------------------------------------------------------------
// One point is taken every cycle while in_ready is high; each passes through
// one front stage, 38 stages of the square-root pipeline (the polar-angle
// cordic runs alongside in 30 stages) and the output register. A stalled
// output freezes the pipeline; a skid register keeps one more point at the
// input. After each configuration transfer the endpoint cordic recomputes
// both arc endpoints in turn, and in_ready stays low while it is busy.
module point_to_arc_distance (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ptad_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ptad_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ptad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_wdata
);

  localparam int LAT = ptad_pkg::LAT_SQRT;
  localparam int DLY = ptad_pkg::THETA_DLY;
  localparam int LW  = ptad_pkg::LEN_W;

  logic signed [31:0] center_x_r, center_y_r, start_angle_r, end_angle_r;
  logic [30:0]        arc_radius_r;
  logic               err_r, err_nxt;
  logic               cfg_fire, in_fire, adv;
  logic               rot_busy;
  ptad_pkg::ep_t      ep;

  logic               skid_v_r;
  ptad_pkg::in_t      skid_r, head;
  logic               head_v;

  logic               fv_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [LW-1:0] e0x_r, e0y_r, e1x_r, e1y_r;

  logic               vld_r [LAT];
  ptad_pkg::ang_t     theta, th_r [DLY];
  logic [ptad_pkg::ROOT_W-1:0] m_len, d0_len, d1_len;

  logic               out_valid_r;
  ptad_pkg::out_t     out_data_r, out_nxt;

  ptad_pkg::ang_t     sa, ea, th;
  logic               wraps, in_span;
  logic signed [ptad_pkg::ROOT_W+1:0] diff;
  logic [ptad_pkg::ROOT_W:0] arc_dist;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = !skid_v_r && !rot_busy;
  assign in_fire   = in_valid && in_ready;
  assign adv       = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      arc_radius_r  <= '0;
      start_angle_r <= '0;
      end_angle_r   <= '0;
      err_r         <= 1'b0;
    end else begin
      err_r <= err_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          ptad_pkg::CFG_CENTER_X:    center_x_r    <= cfg_wdata;
          ptad_pkg::CFG_CENTER_Y:    center_y_r    <= cfg_wdata;
          ptad_pkg::CFG_ARC_RADIUS:  arc_radius_r  <= cfg_wdata[30:0];
          ptad_pkg::CFG_START_ANGLE: start_angle_r <= cfg_wdata;
          ptad_pkg::CFG_END_ANGLE:   end_angle_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign sa = ptad_pkg::ang_t'(start_angle_r);
  assign ea = ptad_pkg::ang_t'(end_angle_r);
  assign err_nxt = (sa < -ptad_pkg::PI_Q) || (sa >= ptad_pkg::PI_Q) ||
                   (ea < -ptad_pkg::PI_Q) || (ea >= ptad_pkg::PI_Q);

  ptad_rot_cordic u_rot (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (cfg_fire),
    .center_x    (center_x_r),
    .center_y    (center_y_r),
    .arc_radius  (arc_radius_r),
    .start_angle (start_angle_r),
    .end_angle   (end_angle_r),
    .busy        (rot_busy),
    .ep          (ep)
  );

  // input skid: holds a transfer taken while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (adv) begin
      skid_v_r <= 1'b0;
    end else if (in_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !adv) skid_r <= in_data;
  end

  assign head_v = skid_v_r || in_fire;
  assign head   = skid_v_r ? skid_r : in_data;

  // front stage: offsets from the center and from both endpoints
  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r  <= 33'(head.point_x) - 33'(center_x_r);
      dy_r  <= 33'(head.point_y) - 33'(center_y_r);
      e0x_r <= LW'(ep.e0x) - LW'(head.point_x);
      e0y_r <= LW'(ep.e0y) - LW'(head.point_y);
      e1x_r <= LW'(ep.e1x) - LW'(head.point_x);
      e1y_r <= LW'(ep.e1y) - LW'(head.point_y);
    end
  end

  ptad_vec_cordic u_vec (
    .clk   (clk),
    .en    (adv),
    .dx    (dx_r),
    .dy    (dy_r),
    .theta (theta)
  );

  ptad_isqrt u_len_c (
    .clk (clk), .en (adv), .a (LW'(dx_r)), .b (LW'(dy_r)), .root (m_len)
  );

  ptad_isqrt u_len_e0 (
    .clk (clk), .en (adv), .a (e0x_r), .b (e0y_r), .root (d0_len)
  );

  ptad_isqrt u_len_e1 (
    .clk (clk), .en (adv), .a (e1x_r), .b (e1y_r), .root (d1_len)
  );

  // valid bits and the angle delay line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      fv_r     <= head_v;
      vld_r[0] <= fv_r;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      th_r[0] <= theta;
      for (int i = 1; i < DLY; i++) th_r[i] <= th_r[i-1];
      out_data_r <= out_nxt;
    end
  end

  // strict-inside test over a span that may wrap through -pi/pi
  always_comb begin
    th      = th_r[DLY-1];
    wraps   = ea < sa;
    in_span = wraps ? !((ea < th) && (th < sa)) : ((sa < th) && (th < ea));
    diff    = (ptad_pkg::ROOT_W + 2)'(arc_radius_r) - (ptad_pkg::ROOT_W + 2)'(m_len);
    if (in_span) begin
      arc_dist = diff[ptad_pkg::ROOT_W+1] ? (ptad_pkg::ROOT_W + 1)'(-diff)
                                          : (ptad_pkg::ROOT_W + 1)'(diff);
    end else begin
      arc_dist = (d0_len < d1_len) ? (ptad_pkg::ROOT_W + 1)'(d0_len)
                                   : (ptad_pkg::ROOT_W + 1)'(d1_len);
    end
    if (err_r) begin
      out_nxt.arc_distance = '0;
      out_nxt.angle_error  = 1'b1;
    end else begin
      out_nxt.arc_distance = (arc_dist > (ptad_pkg::ROOT_W + 1)'(32'hFFFF_FFFF)) ?
                             32'hFFFF_FFFF : arc_dist[31:0];
      out_nxt.angle_error  = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/ptad_checker.sv */
// ----------------------------------------------------------------------------
// ptad_sva
// Port-level checks for point_to_arc_distance, bound to the top level.
// ----------------------------------------------------------------------------
module ptad_sva (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input ptad_pkg::out_t                  out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // bad angle configuration forces a zero distance
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.angle_error |-> out_data.arc_distance == '0)
    else $error("nonzero distance with angle error");

  // a configuration transfer starts the endpoint update, which blocks input
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input accepted during endpoint update");

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind point_to_arc_distance ptad_sva u_ptad_sva (.*);

/* tb/ptad_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptad_checker
// Watches the point, result and register channels of point_to_arc_distance.
// It keeps its own copy of the arc registers, predicts the distance for every
// accepted point, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module ptad_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  ptad_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  ptad_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ptad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  output int                             pending,
  output int                             fail_count,
  output int                             result_count
);

  localparam longint unsigned PI_62 = 64'hC90FDAA22168C234;
  localparam longint KINV = 652032874;
  localparam int FRAC_BITS = ptad_pkg::FRAC_BITS;
  localparam int CORDIC_STEPS = ptad_pkg::CORDIC_STEPS;
  localparam int GUARD = ptad_pkg::GUARD;

  longint atan_step [CORDIC_STEPS];
  longint pi_fix, half_pi_fix;
  longint arc_cx, arc_cy, arc_r, arc_a0, arc_a1;
  ptad_pkg::out_t dist_expected_q [$];

  function automatic longint round_q62(longint unsigned v);
    return longint'((v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS));
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // floor(sqrt(dx^2 + dy^2)), exact at 128 bits
  function automatic longint unsigned vec_length(longint dx, longint dy);
    logic [127:0] ax, ay, n, r, rem, trial;
    ax = 128'(mag(dx));
    ay = 128'(mag(dy));
    n = ax * ax + ay * ay;
    r = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((n >> (2 * i)) & 128'd3);
      trial = (r << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        r = (r << 1) | 128'd1;
      end else begin
        r = r << 1;
      end
    end
    return r[63:0];
  endfunction

  function automatic longint point_angle(longint dx, longint dy);
    longint x, y, z, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = dx;
    y = dy;
    z = 0;
    if (dx < 0) begin
      z = (dy >= 0) ? pi_fix : -pi_fix;
      x = -dx;
      y = -dy;
    end
    while (mag(x) < (64'd1 << 57) && mag(y) < (64'd1 << 57)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_step[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_step[i];
      end
    end
    return z;
  endfunction

  // radius * (cos a, sin a) by rotation cordic with guard bits
  task automatic arc_endpoint(input longint a, output longint ex, output longint ey);
    longint x, y, z, xs, ys;
    bit flip;
    x = (arc_r * KINV) >>> (30 - GUARD);
    y = 0;
    z = a;
    flip = 0;
    if (z > half_pi_fix) begin
      z = z - pi_fix; flip = 1;
    end else if (z < -half_pi_fix) begin
      z = z + pi_fix; flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_step[i];
      end else begin
        x = x + ys; y = y - xs; z = z + atan_step[i];
      end
    end
    x = (x + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    y = (y + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    ex = flip ? -x : x;
    ey = flip ? -y : y;
  endtask

  task automatic predict_distance(input ptad_pkg::in_t p, output ptad_pkg::out_t r);
    longint px, py, dx, dy, th, d, c0, s0, c1, s1;
    longint unsigned arc_dist, d0, d1;
    bit in_span;
    px = longint'(p.point_x);
    py = longint'(p.point_y);
    r = '0;
    if (arc_a0 < -pi_fix || arc_a0 >= pi_fix || arc_a1 < -pi_fix || arc_a1 >= pi_fix) begin
      r.angle_error = 1'b1;
      return;
    end
    dx = px - arc_cx;
    dy = py - arc_cy;
    th = point_angle(dx, dy);
    if (arc_a1 < arc_a0) in_span = !(arc_a1 < th && th < arc_a0);
    else                 in_span = (arc_a0 < th && th < arc_a1);
    if (in_span) begin
      d = arc_r - longint'(vec_length(dx, dy));
      arc_dist = mag(d);
    end else begin
      arc_endpoint(arc_a0, c0, s0);
      arc_endpoint(arc_a1, c1, s1);
      d0 = vec_length(arc_cx + c0 - px, arc_cy + s0 - py);
      d1 = vec_length(arc_cx + c1 - px, arc_cy + s1 - py);
      arc_dist = (d0 < d1) ? d0 : d1;
    end
    r.arc_distance = (arc_dist > 64'hFFFFFFFF) ? 32'hFFFFFFFF : arc_dist[31:0];
  endtask

  initial begin
    longint unsigned acc, term;
    pi_fix = round_q62(PI_62);
    half_pi_fix = longint'((PI_62 + (64'd1 << (62 - FRAC_BITS))) >> (63 - FRAC_BITS));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      acc = 0;
      if (i == 0) begin
        acc = PI_62 >> 2;
      end else begin
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
          term = (64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else            acc = acc + term;
        end
      end
      atan_step[i] = round_q62(acc);
    end
  end

  always @(posedge clk) begin
    ptad_pkg::out_t want;
    if (!rst_n) begin
      arc_cx <= 0; arc_cy <= 0; arc_r <= 0; arc_a0 <= 0; arc_a1 <= 0;
      fail_count <= 0;
      result_count <= 0;
      pending <= 0;
      dist_expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ptad_pkg::CFG_CENTER_X:    arc_cx <= longint'($signed(cfg_wdata));
          ptad_pkg::CFG_CENTER_Y:    arc_cy <= longint'($signed(cfg_wdata));
          ptad_pkg::CFG_ARC_RADIUS:  arc_r  <= longint'(cfg_wdata[30:0]);
          ptad_pkg::CFG_START_ANGLE: arc_a0 <= longint'($signed(cfg_wdata));
          ptad_pkg::CFG_END_ANGLE:   arc_a1 <= longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_distance(in_data, want);
        dist_expected_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (dist_expected_q.size() == 0) begin
          $display("%0t: unexpected result %h, nothing pending", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = dist_expected_q.pop_front();
          if (out_data.arc_distance !== want.arc_distance ||
              out_data.angle_error !== want.angle_error) begin
            $display("%0t: mismatch distance exp %h got %h, error exp %b got %b", $time,
                     want.arc_distance, out_data.arc_distance,
                     want.angle_error, out_data.angle_error);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= dist_expected_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives points and arc settings into point_to_arc_distance under random
// backpressure and gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT_CYCLES = 400000;
  localparam int IDX_W = ptad_pkg::CFG_IDX_W;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  ptad_pkg::in_t        in_data;
  logic                 out_valid;
  logic                 out_ready;
  ptad_pkg::out_t       out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [31:0]          cfg_wdata;

  int pending, fail_count, result_count;
  int tx_idle, rx_idle;
  int hold_cycles;
  int cycle_count;
  int point_count, setting_count;

  logic [31:0] pi_w;

  point_to_arc_distance DUT (.*);

  ptad_checker u_checker (.*);

  initial begin
    clk = 0;
    forever begin
      #5 clk = 1;
      #5 clk = 0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout", $time);
      $display("** point_to_arc_distance: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls plus a single long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_point(input logic [31:0] x, input logic [31:0] y);
    while ($urandom_range(99) < tx_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.point_x = x;
    in_data.point_y = y;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    point_count++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_arc(input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] r,
                         input logic [31:0] a0, input logic [31:0] a1);
    wait_drained();
    write_reg(ptad_pkg::CFG_CENTER_X, cx);
    write_reg(ptad_pkg::CFG_CENTER_Y, cy);
    write_reg(ptad_pkg::CFG_ARC_RADIUS, r);
    write_reg(ptad_pkg::CFG_START_ANGLE, a0);
    write_reg(ptad_pkg::CFG_END_ANGLE, a1);
    setting_count++;
  endtask

  // mostly points within a few units of the center, some fully random
  task automatic random_points(input int n, input logic [31:0] cx, input logic [31:0] cy);
    logic [31:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (point_count >= 240 && point_count < 480) begin
        tx_idle = 48; rx_idle = 26;
      end else if (point_count >= 480) begin
        tx_idle = 0; rx_idle = 0;
      end
      if (point_count == 360) hold_cycles = 300;
      if ($urandom_range(99) < 75) begin
        x = cx + $urandom_range(32'h7FFFFFFF) - 32'h40000000;
        y = cy + $urandom_range(32'h7FFFFFFF) - 32'h40000000;
        if ($urandom_range(9) == 0) y = cy;
      end else begin
        x = $urandom;
        y = $urandom;
      end
      send_point(x, y);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tx_idle = 26;
    rx_idle = 48;
    hold_cycles = 0;
    cycle_count = 0;
    point_count = 0;
    setting_count = 0;
    pi_w = 32'(ptad_pkg::PI_Q);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: empty span at angle zero
    send_point(32'h10000000, 32'h0);
    // quarter arc of radius 1 around the origin
    set_arc(32'h0, 32'h0, 32'h10000000, 32'h0, pi_w >> 1);
    send_point(32'h0, 32'h0);                   // on the center
    send_point(32'hF0000000, 32'h0);            // negative x axis
    send_point(32'h0B000000, 32'h0B000000);     // inside span
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h80000000);
    send_point(32'h80000000, 32'h7FFFFFFF);
    send_point(32'h10000000, 32'hF0000000);     // outside span
    // full circle edges, wrap through -pi/pi
    set_arc(32'h0, 32'h0, 32'h7FFFFFFF, pi_w - 1, -pi_w);
    send_point(32'hF0000000, 32'h0);
    send_point(32'hF0000000, 32'h00000001);
    send_point(32'h12345678, 32'h80000000);
    // saturation: center and point far apart
    set_arc(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -pi_w, pi_w - 1);
    send_point(32'h80000000, 32'h80000000);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
    set_arc(32'h80000000, 32'h80000000, 32'h0, 32'h1, 32'h1);  // start equals end
    send_point(32'h7FFFFFFF, 32'h80000000);
    send_point(32'h80000000, 32'h80000000);
    // angles out of range
    set_arc(32'h0, 32'h0, 32'h10000000, pi_w, 32'h0);
    send_point(32'h1000, 32'h2000);
    set_arc(32'h0, 32'h0, 32'h10000000, 32'h0, -pi_w - 1);
    send_point(32'h1000, 32'h2000);
    set_arc(32'h0, 32'h0, 32'h10000000, 32'h7FFFFFFF, 32'h80000000);
    send_point(32'h0, 32'h0);

    for (int s = 0; s < 8; s++) begin
      logic [31:0] cx, cy, a0, a1;
      cx = (s == 3) ? 32'h7FFFFFFF : (s == 4) ? 32'h80000000 : $urandom;
      cy = (s == 5) ? 32'h80000000 : $urandom;
      a0 = 32'($signed(-pi_w) + $signed($urandom_range(2 * pi_w - 1)));
      a1 = 32'($signed(-pi_w) + $signed($urandom_range(2 * pi_w - 1)));
      if (s == 6) a0 = 32'($signed(a1) + 32'sd1 + $signed($urandom_range(3)));
      set_arc(cx, cy, (s == 2) ? 32'h7FFFFFFF : $urandom_range(32'h3FFFFFFF), a0, a1);
      random_points(85, cx, cy);
    end

    wait_drained();
    repeat (60) @(posedge clk);
    $display("covered %0d points over %0d arc settings, %0d results checked",
             point_count, setting_count, result_count);
    if (fail_count == 0) begin
      $display("** point_to_arc_distance: PASSED **");
    end else begin
      $display("** point_to_arc_distance: FAILED **");
    end
    $finish;
  end

endmodule

/* point_to_arc_distance.f */
rtl/ptad_pkg.sv
rtl/ptad_vec_cordic.sv
rtl/ptad_isqrt.sv
rtl/ptad_rot_cordic.sv
rtl/point_to_arc_distance.sv
rtl/ptad_checker.sv
tb/ptad_checker.sv
tb/testbench.sv
